// ----- design/swq_pkg.sv -----
// Package for the semaphore wait-queue manager.
// Field widths, command and status codes, default sizes and the
// control/status structs between the sequencer and the key scan unit.
package swq_pkg;

  // Transaction field widths
  localparam int CMD_W    = 2;
  localparam int KEY_W    = 32;
  localparam int PROC_W   = 5;
  localparam int STATUS_W = 2;

  // Default sizes
  localparam int MAX_PROCS_DEF = 32;
  localparam int KEY_BITS_DEF  = 32;

  // Commands
  localparam logic [CMD_W-1:0] CMD_BLOCK    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WITHDRAW = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK     = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] STS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NO_FREE   = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;

  // Sequencer to key scan unit
  typedef struct packed {
    logic start;  // begin a key search over all descriptors
    logic alloc;  // claim descriptor and store its key
    logic drop;   // free descriptor
  } scan_ctl_t;

  // Key scan unit to sequencer
  typedef struct packed {
    logic done;     // search finished this cycle
    logic hit;      // key found in a descriptor in use
    logic free_ok;  // a free descriptor was seen
  } scan_sts_t;

endpackage

// ----- design/swq_if.sv -----
// Request and response channel interfaces of the semaphore wait-queue manager.
// Depends on swq_pkg for the field widths.
interface swq_req_if import swq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KEY_W-1:0]  sem_key;
  logic [PROC_W-1:0] proc_id;

  modport source (output valid, output command, output sem_key, output proc_id, input ready);
  modport sink   (input valid, input command, input sem_key, input proc_id, output ready);
endinterface

interface swq_rsp_if import swq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PROC_W-1:0]   result_proc;

  modport source (output valid, output status, output result_proc, input ready);
  modport sink   (input valid, input status, input result_proc, output ready);
endinterface

// ----- design/swq_key_scan.sv -----
// Descriptor key store with its in-use flags and the shared key comparator.
// Walks the descriptors one per cycle; also finds the lowest free one.
// Depends on swq_pkg.
module swq_key_scan import swq_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scan_ctl_t                     ctl_i,
  input  logic [((KEY_BITS < KEY_W) ? KEY_BITS : KEY_W)-1:0] key_i,
  input  logic [$clog2(MAX_PROCS)-1:0]  slot_i,
  output scan_sts_t                     sts_o,
  output logic [$clog2(MAX_PROCS)-1:0]  hit_slot_o,
  output logic [$clog2(MAX_PROCS)-1:0]  free_slot_o
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int CW = PW + 1;
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  logic [KW-1:0]        key_mem [MAX_PROCS];
  logic [KW-1:0]        rd_key_q;
  logic [MAX_PROCS-1:0] in_use_q;
  logic [CW-1:0]        scan_q;
  logic [PW-1:0]        rd_idx_q;
  logic                 rd_vld_q;
  logic                 busy_q;
  logic                 free_ok_q;
  logic [PW-1:0]        free_slot_q;

  logic cur_used, hit, last, done;

  assign cur_used = in_use_q[rd_idx_q];
  assign hit      = rd_vld_q && cur_used && (rd_key_q == key_i);
  assign last     = rd_vld_q && (rd_idx_q == PW'(MAX_PROCS - 1));
  assign done     = busy_q && (hit || last);

  assign sts_o.done    = done;
  assign sts_o.hit     = hit;
  assign sts_o.free_ok = free_ok_q || (rd_vld_q && !cur_used);
  assign hit_slot_o    = rd_idx_q;
  assign free_slot_o   = free_ok_q ? free_slot_q : rd_idx_q;

  // key store: one write, one registered read at the scan pointer
  always_ff @(posedge clk_i) begin
    if (ctl_i.alloc) begin
      key_mem[slot_i] <= key_i;
    end
    rd_key_q <= key_mem[scan_q[PW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= '0;
      busy_q      <= 1'b0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      free_ok_q   <= 1'b0;
      free_slot_q <= '0;
    end else begin
      if (ctl_i.alloc) begin
        in_use_q[slot_i] <= 1'b1;
      end
      if (ctl_i.drop) begin
        in_use_q[slot_i] <= 1'b0;
      end
      if (ctl_i.start) begin
        busy_q    <= 1'b1;
        scan_q    <= '0;
        rd_vld_q  <= 1'b0;
        free_ok_q <= 1'b0;
      end else if (busy_q) begin
        if (done) begin
          busy_q   <= 1'b0;
          rd_vld_q <= 1'b0;
        end else begin
          rd_vld_q <= (scan_q < CW'(MAX_PROCS));
          rd_idx_q <= scan_q[PW-1:0];
          if (scan_q < CW'(MAX_PROCS)) begin
            scan_q <= scan_q + CW'(1);
          end
          if (rd_vld_q && !cur_used && !free_ok_q) begin
            free_ok_q   <= 1'b1;
            free_slot_q <= rd_idx_q;
          end
        end
      end
    end
  end

endmodule

// ----- design/semaphore_wait_queue_manager.sv -----
// Semaphore wait-queue manager: one transaction in, one result out.
// Block, wake and peek run a key search over the descriptors; wake and
// withdraw then unlink a process, withdraw walking the queue entries.
// One command at a time; the next is taken the cycle after its result is
// registered, even while that result still waits. Reset (async, active low)
// frees all descriptors and clears every waiting flag at once; no clearing pass.
module semaphore_wait_queue_manager import swq_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swq_req_if.sink   req_i,
  swq_rsp_if.source rsp_o
);

  localparam int PW = $clog2(MAX_PROCS);
  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_APPEND   = 4'd3;
  localparam logic [3:0] S_HEAD     = 4'd4;
  localparam logic [3:0] S_WD_SLOT  = 4'd5;
  localparam logic [3:0] S_UL_ISSUE = 4'd6;
  localparam logic [3:0] S_UL_CHK   = 4'd7;
  localparam logic [3:0] S_UL_HL    = 4'd8;
  localparam logic [3:0] S_WALK     = 4'd9;
  localparam logic [3:0] S_SPLICE   = 4'd10;
  localparam logic [3:0] S_RESP     = 4'd11;

  logic [3:0] state_q, state_d;

  // latched command
  logic [CMD_W-1:0]  cmd_q;
  logic [KW-1:0]     key_q;
  logic [PROC_W-1:0] p_q;
  logic [PW-1:0]     pidx;
  logic              p_ok;

  // working registers
  logic [PW-1:0] s_q, s_d;       // descriptor being worked on
  logic [PW-1:0] tgt_q, tgt_d;   // process being unlinked
  logic [PW-1:0] cur_q, cur_d;   // walk pointer
  logic [PW-1:0] tail_q, tail_d; // tail of queue during unlink

  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [PW-1:0]       res_proc_q, res_proc_d;

  logic [MAX_PROCS-1:0] waiting_q, waiting_d;

  // output register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [PROC_W-1:0]   out_proc_q;
  logic                out_load;

  // per-descriptor and per-process stores
  logic [PW-1:0] head_mem  [MAX_PROCS];
  logic [PW-1:0] tail_mem  [MAX_PROCS];
  logic [PW-1:0] link_mem  [MAX_PROCS];
  logic [PW-1:0] pslot_mem [MAX_PROCS];

  logic [PW-1:0] head_rd_q, tail_rd_q, link_rd_q, pslot_rd_q;
  logic [PW-1:0] head_ra, tail_ra, link_ra, pslot_ra;
  logic          head_we, tail_we, link_we, pslot_we;
  logic [PW-1:0] head_wa, tail_wa, link_wa, pslot_wa;
  logic [PW-1:0] head_wd, tail_wd, link_wd, pslot_wd;

  // key scan unit
  scan_ctl_t     scan_ctl;
  scan_sts_t     scan_sts;
  logic [PW-1:0] scan_slot;
  logic [PW-1:0] hit_slot;
  logic [PW-1:0] free_slot;

  logic accept;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  assign pidx = PW'(p_q);
  assign p_ok = (32'(p_q) < 32'(MAX_PROCS));

  swq_key_scan #(
    .MAX_PROCS (MAX_PROCS),
    .KEY_BITS  (KEY_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .key_i       (key_q),
    .slot_i      (scan_slot),
    .sts_o       (scan_sts),
    .hit_slot_o  (hit_slot),
    .free_slot_o (free_slot)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    s_d          = s_q;
    tgt_d        = tgt_q;
    cur_d        = cur_q;
    tail_d       = tail_q;
    res_status_d = res_status_q;
    res_proc_d   = res_proc_q;
    waiting_d    = waiting_q;

    scan_ctl  = '0;
    scan_slot = s_q;

    head_ra  = s_q;
    tail_ra  = s_q;
    link_ra  = cur_q;
    pslot_ra = pidx;

    head_we  = 1'b0;
    tail_we  = 1'b0;
    link_we  = 1'b0;
    pslot_we = 1'b0;
    head_wa  = s_q;
    tail_wa  = s_q;
    link_wa  = cur_q;
    pslot_wa = pidx;
    head_wd  = pidx;
    tail_wd  = pidx;
    link_wd  = pidx;
    pslot_wd = s_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        case (cmd_q)
          CMD_BLOCK: begin
            if (!p_ok || waiting_q[pidx]) begin
              res_status_d = STS_NOT_FOUND;
              res_proc_d   = '0;
              state_d      = S_RESP;
            end else begin
              scan_ctl.start = 1'b1;
              state_d        = S_SCAN;
            end
          end
          CMD_WITHDRAW: begin
            if (!p_ok || !waiting_q[pidx]) begin
              res_status_d = STS_NOT_FOUND;
              res_proc_d   = '0;
              state_d      = S_RESP;
            end else begin
              pslot_ra = pidx;
              tgt_d    = pidx;
              state_d  = S_WD_SLOT;
            end
          end
          default: begin
            scan_ctl.start = 1'b1;
            state_d        = S_SCAN;
          end
        endcase
      end

      S_SCAN: begin
        if (scan_sts.done) begin
          if (cmd_q == CMD_BLOCK) begin
            if (scan_sts.hit) begin
              tail_ra = hit_slot;
              s_d     = hit_slot;
              state_d = S_APPEND;
            end else if (scan_sts.free_ok) begin
              // new key: claim lowest free descriptor, queue of one
              scan_ctl.alloc   = 1'b1;
              scan_slot        = free_slot;
              head_we          = 1'b1;
              head_wa          = free_slot;
              head_wd          = pidx;
              tail_we          = 1'b1;
              tail_wa          = free_slot;
              tail_wd          = pidx;
              pslot_we         = 1'b1;
              pslot_wa         = pidx;
              pslot_wd         = free_slot;
              waiting_d[pidx]  = 1'b1;
              res_status_d     = STS_DONE;
              res_proc_d       = pidx;
              state_d          = S_RESP;
            end else begin
              res_status_d = STS_NO_FREE;
              res_proc_d   = '0;
              state_d      = S_RESP;
            end
          end else begin
            if (scan_sts.hit) begin
              head_ra = hit_slot;
              s_d     = hit_slot;
              state_d = S_HEAD;
            end else begin
              res_status_d = STS_NOT_FOUND;
              res_proc_d   = '0;
              state_d      = S_RESP;
            end
          end
        end
      end

      S_APPEND: begin
        link_we         = 1'b1;
        link_wa         = tail_rd_q;
        link_wd         = pidx;
        tail_we         = 1'b1;
        tail_wa         = s_q;
        tail_wd         = pidx;
        pslot_we        = 1'b1;
        pslot_wa        = pidx;
        pslot_wd        = s_q;
        waiting_d[pidx] = 1'b1;
        res_status_d    = STS_DONE;
        res_proc_d      = pidx;
        state_d         = S_RESP;
      end

      S_HEAD: begin
        if (cmd_q == CMD_WAKE) begin
          tgt_d   = head_rd_q;
          state_d = S_UL_ISSUE;
        end else begin
          res_status_d = STS_DONE;
          res_proc_d   = head_rd_q;
          state_d      = S_RESP;
        end
      end

      S_WD_SLOT: begin
        s_d     = pslot_rd_q;
        state_d = S_UL_ISSUE;
      end

      S_UL_ISSUE: begin
        head_ra = s_q;
        tail_ra = s_q;
        state_d = S_UL_CHK;
      end

      S_UL_CHK: begin
        tail_d = tail_rd_q;
        if (head_rd_q == tgt_q) begin
          if (tail_rd_q == tgt_q) begin
            // last entry leaves: descriptor goes back to the pool
            scan_ctl.drop    = 1'b1;
            scan_slot        = s_q;
            waiting_d[tgt_q] = 1'b0;
            res_status_d     = STS_DONE;
            res_proc_d       = tgt_q;
            state_d          = S_RESP;
          end else begin
            link_ra = tgt_q;
            state_d = S_UL_HL;
          end
        end else begin
          cur_d   = head_rd_q;
          link_ra = head_rd_q;
          state_d = S_WALK;
        end
      end

      S_UL_HL: begin
        head_we          = 1'b1;
        head_wa          = s_q;
        head_wd          = link_rd_q;
        waiting_d[tgt_q] = 1'b0;
        res_status_d     = STS_DONE;
        res_proc_d       = tgt_q;
        state_d          = S_RESP;
      end

      S_WALK: begin
        // link_rd_q holds the successor of cur_q
        if (link_rd_q == tgt_q) begin
          link_ra = tgt_q;
          state_d = S_SPLICE;
        end else if (cur_q == tail_q) begin
          waiting_d[tgt_q] = 1'b0;
          res_status_d     = STS_DONE;
          res_proc_d       = tgt_q;
          state_d          = S_RESP;
        end else begin
          cur_d   = link_rd_q;
          link_ra = link_rd_q;
        end
      end

      S_SPLICE: begin
        link_we = 1'b1;
        link_wa = cur_q;
        link_wd = link_rd_q;
        if (tail_q == tgt_q) begin
          tail_we = 1'b1;
          tail_wa = s_q;
          tail_wd = cur_q;
        end
        waiting_d[tgt_q] = 1'b0;
        res_status_d     = STS_DONE;
        res_proc_d       = tgt_q;
        state_d          = S_RESP;
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_load = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  // stores: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (tail_we) begin
      tail_mem[tail_wa] <= tail_wd;
    end
    tail_rd_q <= tail_mem[tail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pslot_we) begin
      pslot_mem[pslot_wa] <= pslot_wd;
    end
    pslot_rd_q <= pslot_mem[pslot_ra];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.command;
      key_q <= req_i.sem_key[KW-1:0];
      p_q   <= req_i.proc_id;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q          <= s_d;
    tgt_q        <= tgt_d;
    cur_q        <= cur_d;
    tail_q       <= tail_d;
    res_status_q <= res_status_d;
    res_proc_q   <= res_proc_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_proc_q   <= PROC_W'(res_proc_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      waiting_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      waiting_q <= waiting_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.result_proc = out_proc_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for semaphore_wait_queue_manager.
// Drives block, wake, withdraw and peek transactions and checks every result
// against a typed-in value or a linked-list pool model; needs swq_pkg and swq_if.
`timescale 1ns / 100ps

module testbench;
  import swq_pkg::*;

  localparam int NPROC      = MAX_PROCS_DEF;
  localparam int RAND_ITEMS = 1500;
  localparam int CALM_ITEMS = 200;   // closing stretch with no idling
  localparam int DRAIN_WAIT = 64;    // longer than the slowest command

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PROC_W-1:0]   proc;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    logic [PROC_W-1:0]   pid;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [PROC_W-1:0]   proc;
  } cmd_row_t;

  logic clk_i;
  logic rst_ni;

  swq_req_if req ();
  swq_rsp_if rsp ();

  semaphore_wait_queue_manager u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Model of the descriptor pool: each busy descriptor owns a FIFO of
  // waiting processes, linked through next_proc.
  logic               desc_busy  [NPROC];
  logic [KEY_W-1:0]   desc_key   [NPROC];
  logic [PROC_W-1:0]  desc_head  [NPROC];
  logic [PROC_W-1:0]  desc_tail  [NPROC];
  logic [PROC_W-1:0]  next_proc  [NPROC];
  logic [PROC_W-1:0]  proc_desc  [NPROC];
  logic               proc_blocked [NPROC];

  result_t pending_results [$];
  int      err_count;
  logic    idle_on;

  // Hand-typed expectation riding along with the transaction being offered
  logic                typed_on;
  logic [STATUS_W-1:0] typed_status;
  logic [PROC_W-1:0]   typed_proc;

  // Directed part: error codes, echoes and extremes are typed in; rows whose
  // result depends on queue order are left to the model. Covers empty pool,
  // key/proc extremes, a process blocked twice, middle and tail withdrawal,
  // head removal by wake, and descriptors freed on emptying.
  cmd_row_t dir_rows [0:24] = '{
    '{CMD_WAKE,     32'h0000_0000, 5'd0,  1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_PEEK,     32'hFFFF_FFFF, 5'd0,  1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_WITHDRAW, 32'h0000_0000, 5'd0,  1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_WITHDRAW, 32'hFFFF_FFFF, 5'd31, 1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_BLOCK,    32'h0000_0000, 5'd0,  1'b1, STS_DONE,      5'd0},
    '{CMD_BLOCK,    32'hFFFF_FFFF, 5'd31, 1'b1, STS_DONE,      5'd31},
    '{CMD_BLOCK,    32'h0000_0000, 5'd31, 1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_BLOCK,    32'h0000_0000, 5'd21, 1'b1, STS_DONE,      5'd21},
    '{CMD_BLOCK,    32'h0000_0000, 5'd10, 1'b1, STS_DONE,      5'd10},
    '{CMD_PEEK,     32'h0000_0000, 5'd7,  1'b0, STS_DONE,      5'd0},
    '{CMD_PEEK,     32'hFFFF_FFFF, 5'd0,  1'b0, STS_DONE,      5'd0},
    '{CMD_WITHDRAW, 32'h1234_5678, 5'd21, 1'b1, STS_DONE,      5'd21},
    '{CMD_WAKE,     32'h0000_0000, 5'd0,  1'b0, STS_DONE,      5'd0},
    '{CMD_PEEK,     32'h0000_0000, 5'd0,  1'b0, STS_DONE,      5'd0},
    '{CMD_WITHDRAW, 32'h0000_0000, 5'd10, 1'b1, STS_DONE,      5'd10},
    '{CMD_PEEK,     32'h0000_0000, 5'd0,  1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_BLOCK,    32'hAAAA_AAAA, 5'd1,  1'b1, STS_DONE,      5'd1},
    '{CMD_BLOCK,    32'h5555_5555, 5'd2,  1'b1, STS_DONE,      5'd2},
    '{CMD_BLOCK,    32'hAAAA_AAAA, 5'd3,  1'b1, STS_DONE,      5'd3},
    '{CMD_WITHDRAW, 32'h0000_0000, 5'd3,  1'b1, STS_DONE,      5'd3},
    '{CMD_BLOCK,    32'hAAAA_AAAA, 5'd4,  1'b1, STS_DONE,      5'd4},
    '{CMD_WAKE,     32'hAAAA_AAAA, 5'd0,  1'b0, STS_DONE,      5'd0},
    '{CMD_WAKE,     32'hAAAA_AAAA, 5'd0,  1'b0, STS_DONE,      5'd0},
    '{CMD_WAKE,     32'hAAAA_AAAA, 5'd0,  1'b1, STS_NOT_FOUND, 5'd0},
    '{CMD_WAKE,     32'hFFFF_FFFF, 5'd0,  1'b0, STS_DONE,      5'd0}
  };

  function automatic int find_desc(input logic [KEY_W-1:0] key);
    int s;
    find_desc = -1;
    for (s = 0; s < NPROC; s++) begin
      if (desc_busy[s] && desc_key[s] == key && find_desc < 0) find_desc = s;
    end
  endfunction

  // Take a waiting process out of its descriptor's FIFO; an emptied
  // descriptor goes back to the pool.
  function automatic void detach_waiter(input int s, input logic [PROC_W-1:0] pid);
    logic [PROC_W-1:0] cur;
    int n;
    cur = desc_head[s];
    if (cur == pid) begin
      if (desc_tail[s] == pid) desc_busy[s] = 1'b0;
      else desc_head[s] = next_proc[pid];
    end else begin
      for (n = 0; n < NPROC; n++) begin
        if (next_proc[cur] == pid) begin
          next_proc[cur] = next_proc[pid];
          if (desc_tail[s] == pid) desc_tail[s] = cur;
          break;
        end
        cur = next_proc[cur];
      end
    end
    proc_blocked[pid] = 1'b0;
  endfunction

  function automatic result_t apply_semaphore_cmd(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PROC_W-1:0] pid);
    result_t r;
    int s;
    int f;
    r.status = STS_NOT_FOUND;
    r.proc   = '0;
    case (cmd)
      CMD_BLOCK: begin
        if (!proc_blocked[pid]) begin
          s = find_desc(key);
          if (s >= 0) begin
            next_proc[desc_tail[s]] = pid;
            desc_tail[s] = pid;
          end else begin
            for (f = NPROC - 1; f >= 0; f--) if (!desc_busy[f]) s = f;
            if (s >= 0) begin
              desc_busy[s] = 1'b1;
              desc_key[s]  = key;
              desc_head[s] = pid;
              desc_tail[s] = pid;
            end
          end
          if (s < 0) begin
            r.status = STS_NO_FREE;
          end else begin
            proc_desc[pid]    = s[PROC_W-1:0];
            proc_blocked[pid] = 1'b1;
            r.status = STS_DONE;
            r.proc   = pid;
          end
        end
      end
      CMD_WITHDRAW: begin
        if (proc_blocked[pid]) begin
          detach_waiter(proc_desc[pid], pid);
          r.status = STS_DONE;
          r.proc   = pid;
        end
      end
      default: begin  // wake and peek both act on the head
        s = find_desc(key);
        if (s >= 0) begin
          r.status = STS_DONE;
          r.proc   = desc_head[s];
          if (cmd == CMD_WAKE) detach_waiter(s, desc_head[s]);
        end
      end
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Guard against a hung block
  initial begin
    #20_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Result side: ready drops in random bursts while idling is on
  initial begin : rsp_ready_gen
    int stall_left;
    stall_left = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= rst_ni;
      end
    end
  end

  // Monitor: predict on each accepted command, check each accepted result.
  // A new command can be taken while the previous result still waits, so the
  // expectation is queued before the pop and the oldest one is compared.
  always @(posedge clk_i) begin : monitor
    result_t exp_r;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        exp_r = apply_semaphore_cmd(req.command, req.sem_key, req.proc_id);
        if (typed_on) begin
          exp_r.status = typed_status;
          exp_r.proc   = typed_proc;
        end
        pending_results.push_back(exp_r);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: status %0d proc %0d", rsp.status, rsp.result_proc);
        end else begin
          exp_r = pending_results.pop_front();
          if (rsp.status !== exp_r.status || rsp.result_proc !== exp_r.proc) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch at %0t: status exp %0d got %0d, proc exp %0d got %0d",
                       $realtime, exp_r.status, rsp.status, exp_r.proc, rsp.result_proc);
          end
        end
      end
    end
  end

  // Offer one transaction and hold it until accepted. Entered and left at a
  // falling edge; valid sees a single update per edge.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                          input logic [PROC_W-1:0] pid, input logic typed,
                          input logic [STATUS_W-1:0] sts, input logic [PROC_W-1:0] rproc);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid    <= 1'b1;
    req.command  <= cmd;
    req.sem_key  <= key;
    req.proc_id  <= pid;
    typed_on     <= typed;
    typed_status <= sts;
    typed_proc   <= rproc;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    logic [KEY_W-1:0]  key_pool [NPROC];
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [PROC_W-1:0] pid;
    int i;
    int n;
    int roll;
    int fill_bias;
    int key_span;

    rst_ni       = 1'b0;
    req.valid    = 1'b0;
    req.command  = CMD_BLOCK;
    req.sem_key  = '0;
    req.proc_id  = '0;
    typed_on     = 1'b0;
    typed_status = STS_DONE;
    typed_proc   = '0;
    idle_on      = 1'b1;
    err_count    = 0;
    fill_bias    = 50;
    key_span     = 4;
    for (i = 0; i < NPROC; i++) begin
      desc_busy[i]    = 1'b0;
      desc_key[i]     = '0;
      desc_head[i]    = '0;
      desc_tail[i]    = '0;
      next_proc[i]    = '0;
      proc_desc[i]    = '0;
      proc_blocked[i] = 1'b0;
      key_pool[i]     = '0;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < $size(dir_rows); i++)
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].pid,
               dir_rows[i].typed, dir_rows[i].status, dir_rows[i].proc);

    // Random part in phases: each phase has its own key pool size and its
    // own lean towards filling or draining the queues.
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % 250 == 0) begin
        fill_bias = $urandom_range(25, 70);
        case ($urandom_range(0, 3))
          0: key_span = 1;
          1: key_span = 4;
          2: key_span = 8;
          default: key_span = NPROC;
        endcase
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (i = 2; i < NPROC; i++) key_pool[i] = $urandom;
      end
      idle_on = (n < RAND_ITEMS - CALM_ITEMS);

      key = key_pool[$urandom_range(0, key_span - 1)];
      if ($urandom_range(0, 19) == 0) key = $urandom;   // now and then an unknown key
      pid = PROC_W'($urandom_range(0, NPROC - 1));
      roll = $urandom_range(0, 99);
      if (roll < fill_bias) cmd = CMD_BLOCK;
      else if (roll < fill_bias + (100 - fill_bias) / 3) cmd = CMD_WAKE;
      else if (roll < fill_bias + 2 * (100 - fill_bias) / 3) cmd = CMD_WITHDRAW;
      else cmd = CMD_PEEK;

      // Withdraw mostly aims at a process that is really waiting
      if (cmd == CMD_WITHDRAW && $urandom_range(0, 9) != 0) begin
        for (i = 0; i < NPROC && !proc_blocked[pid]; i++)
          pid = PROC_W'($urandom_range(0, NPROC - 1));
      end

      send_cmd(cmd, key, pid, 1'b0, STS_DONE, '0);
    end
    req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/swq_pkg.sv
design/swq_if.sv
design/swq_key_scan.sv
design/semaphore_wait_queue_manager.sv
test/testbench.sv
